>>> design/tspd_pkg.sv
// ============================================================================
// tspd_pkg - shared types, constants and functions of the pixel decoder
// Holds the request kinds, store sizes, colour weights and the control
// structs that travel between the pipeline stages.
// ============================================================================
`default_nettype none

package tspd_pkg;

    // Store sizes in bytes.
    localparam int COLOUR_ROM_BYTES  = 32;
    localparam int PALETTE_ROM_BYTES = 256;
    localparam int TILE_ROM_BYTES    = 4096;
    localparam int SPRITE_ROM_BYTES  = 4096;

    // Address widths of the fixed-size stores.
    localparam int COLOUR_AW  = 5;
    localparam int PATTERN_AW = 12;

    // Quotient of a 12-bit load address by a palette size of at least 128.
    localparam int PAL_Q_W = 5;

    // Shift used for the reciprocal that reduces palette load addresses.
    localparam int PAL_RECIP_SHIFT = 24;

    // Request kinds, carried in tuser.
    localparam logic [2:0] KIND_LOAD_COLOUR  = 3'd0;
    localparam logic [2:0] KIND_LOAD_PALETTE = 3'd1;
    localparam logic [2:0] KIND_LOAD_TILE    = 3'd2;
    localparam logic [2:0] KIND_LOAD_SPRITE  = 3'd3;
    localparam logic [2:0] KIND_TILE_PIXEL   = 3'd4;
    localparam logic [2:0] KIND_SPRITE_PIXEL = 3'd5;

    // Resistor weights of the colour byte.
    localparam logic [7:0] W_RG0 = 8'h21;
    localparam logic [7:0] W_RG1 = 8'h47;
    localparam logic [7:0] W_RG2 = 8'h97;
    localparam logic [7:0] W_B0  = 8'h51;
    localparam logic [7:0] W_B1  = 8'hAE;

    // One decoded request.
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [7:0]  pattern_index;
        logic [7:0]  palette_index;
        logic [3:0]  pixel_x;
        logic [3:0]  pixel_y;
        logic        mirror_x;
        logic        mirror_y;
    } t_req;

    // Control leaving the pattern stage.
    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         pal;
        logic [1:0]         bit_sel;
        logic [11:0]        load_address;
        logic [7:0]         load_data;
        logic [PAL_Q_W-1:0] pal_quot;
    } t_pat_ctl;

    // Control leaving the palette stage.
    typedef struct packed {
        logic [2:0]           kind;
        logic [1:0]           code;
        logic [COLOUR_AW-1:0] colour_addr;
        logic [7:0]           load_data;
    } t_pal_ctl;

    // Control leaving the colour stage.
    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] code;
    } t_col_ctl;

    // Three-bit red or green intensity, wrapped to eight bits.
    function automatic logic [7:0] weigh_rg(input logic [2:0] bits);
        logic [7:0] sum;
        sum = 8'd0;
        if (bits[0]) sum = sum + W_RG0;
        if (bits[1]) sum = sum + W_RG1;
        if (bits[2]) sum = sum + W_RG2;
        return sum;
    endfunction

    // Two-bit blue intensity, wrapped to eight bits.
    function automatic logic [7:0] weigh_b(input logic [1:0] bits);
        logic [7:0] sum;
        sum = 8'd0;
        if (bits[0]) sum = sum + W_B0;
        if (bits[1]) sum = sum + W_B1;
        return sum;
    endfunction

endpackage

`default_nettype wire

>>> design/tile_sprite_pixel_decoder_unit.sv
// A pixel item passes through the pattern, palette, colour and output registers in turn.
// One item per cycle while the output is not stalled; the four stages each hold one item.
// The pattern, palette and colour store reads are each one registered stage.
// Reset clears all valid bits; the stores are not cleared and hold no data
// until loaded.
// ============================================================================
// tile_sprite_pixel_decoder_unit - tile and sprite pixel decoder
// Load items fill the colour, palette, tile pattern and sprite pattern
// stores. Pixel items decode one pixel to a two-bit code, look it up through
// the palette and colour stores and weigh the colour byte into 8-bit RGB.
// ============================================================================
`default_nettype none

module tile_sprite_pixel_decoder_unit #(
    parameter int PALETTE_ROM_BYTES = tspd_pkg::PALETTE_ROM_BYTES
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input item stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: load_address[11:0], load_data[19:12],
    // pattern_index[27:20], palette_index[35:28], pixel_x[39:36],
    // pixel_y[43:40], mirror_x[44], mirror_y[45], zero padding[47:46].
    input  wire  [47:0] s_axis_tdata,
    // Fields from bit 0: req_type[2:0].
    input  wire  [2:0]  s_axis_tuser,
    // Result item stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16], transparent[24],
    // colour_code[26:25], zero padding[31:27].
    output logic [31:0] m_axis_tdata
);

    // The pipeline runs in four stages:
    //   1. pattern address decode and pattern store read (tile and sprite loads land here),
    //   2. plane bit pick and palette reads for the code and entry zero (palette loads),
    //   3. colour store reads for both palette entries (colour loads),
    //   4. resistor weighting and the output register.
    // Each store is written in the same stage that reads it, so loads and
    // pixel items keep their order. Each stage stalls only when it is full
    // and the stage after it is stalled, so bubbles close up and input keeps
    // flowing while a result waits at the output.

    tspd_pkg::t_req     w_req;
    tspd_pkg::t_pat_ctl w_pat_ctl;
    tspd_pkg::t_pal_ctl w_pal_ctl;
    tspd_pkg::t_col_ctl w_col_ctl;

    logic       w_s1_valid;
    logic       w_s1_ready_in;
    logic       w_s2_valid;
    logic       w_s2_ready_in;
    logic       w_s3_valid;
    logic [7:0] w_pattern_byte;
    logic [7:0] w_entry;
    logic [7:0] w_entry0;
    logic [7:0] w_colour;
    logic [7:0] w_colour0;
    logic       w_out_en;
    logic       w_s3_pixel;

    logic       r_out_valid;
    logic [7:0] r_red;
    logic [7:0] r_green;
    logic [7:0] r_blue;
    logic       r_transparent;
    logic [1:0] r_code;
    logic       n_transparent;

    always_comb begin
        w_req.kind          = s_axis_tuser;
        w_req.load_address  = s_axis_tdata[11:0];
        w_req.load_data     = s_axis_tdata[19:12];
        w_req.pattern_index = s_axis_tdata[27:20];
        w_req.palette_index = s_axis_tdata[35:28];
        w_req.pixel_x       = s_axis_tdata[39:36];
        w_req.pixel_y       = s_axis_tdata[43:40];
        w_req.mirror_x      = s_axis_tdata[44];
        w_req.mirror_y      = s_axis_tdata[45];
    end

    tspd_pattern_stage #(
        .PaletteRomBytes (PALETTE_ROM_BYTES)
    ) u_pattern (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_req          (w_req),
        .o_ready        (s_axis_tready),
        .i_ready        (w_s1_ready_in),
        .o_valid        (w_s1_valid),
        .o_ctl          (w_pat_ctl),
        .o_pattern_byte (w_pattern_byte)
    );

    tspd_palette_stage #(
        .PaletteRomBytes (PALETTE_ROM_BYTES)
    ) u_palette (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_s1_valid),
        .i_ctl          (w_pat_ctl),
        .i_pattern_byte (w_pattern_byte),
        .o_ready        (w_s1_ready_in),
        .i_ready        (w_s2_ready_in),
        .o_valid        (w_s2_valid),
        .o_ctl          (w_pal_ctl),
        .o_entry        (w_entry),
        .o_entry0       (w_entry0)
    );

    tspd_colour_stage u_colour (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s2_valid),
        .i_ctl     (w_pal_ctl),
        .i_entry   (w_entry),
        .i_entry0  (w_entry0),
        .o_ready   (w_s2_ready_in),
        .i_ready   (w_out_en),
        .o_valid   (w_s3_valid),
        .o_ctl     (w_col_ctl),
        .o_colour  (w_colour),
        .o_colour0 (w_colour0)
    );

    // Only pixel items make a result; loads and unused kinds end here.
    assign w_out_en   = !r_out_valid || m_axis_tready;
    assign w_s3_pixel = (w_col_ctl.kind == tspd_pkg::KIND_TILE_PIXEL) ||
                        (w_col_ctl.kind == tspd_pkg::KIND_SPRITE_PIXEL);

    // A sprite pixel is transparent when its colour matches palette entry zero.
    assign n_transparent = (w_col_ctl.kind == tspd_pkg::KIND_SPRITE_PIXEL) &&
                           (w_colour == w_colour0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_en) begin
            r_out_valid <= w_s3_valid && w_s3_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_red         <= tspd_pkg::weigh_rg(w_colour[2:0]);
            r_green       <= tspd_pkg::weigh_rg(w_colour[5:3]);
            r_blue        <= tspd_pkg::weigh_b(w_colour[7:6]);
            r_transparent <= n_transparent;
            r_code        <= w_col_ctl.code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_code, r_transparent, r_blue, r_green, r_red};

`ifndef ASSERT_OFF
    // A pixel item leaving the colour stage must become a result.
    a_pixel_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s3_valid && w_s3_pixel && w_out_en) |=> r_out_valid)
        else $error("pixel item lost at the output register");

    // Nothing else may create a result.
    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_en && !(w_s3_valid && w_s3_pixel)) |=> !r_out_valid)
        else $error("result produced without a pixel item");

    // Input stalls only when the first stage actually holds an item.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_s1_valid)
        else $error("input stalled with an empty first stage");
`endif

endmodule

`default_nettype wire

>>> design/tspd_pattern_stage.sv
// ============================================================================
// tspd_pattern_stage - pattern address decode and pattern store access
// Undoes the tile and sprite pattern layout, reads the pattern byte and
// takes tile and sprite pattern loads.
// ============================================================================
`default_nettype none

module tspd_pattern_stage #(
    parameter int PaletteRomBytes = tspd_pkg::PALETTE_ROM_BYTES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  tspd_pkg::t_req      i_req,
    output logic                o_ready,
    input  wire                 i_ready,
    output logic                o_valid,
    output tspd_pkg::t_pat_ctl  o_ctl,
    output logic [7:0]          o_pattern_byte
);

    localparam int RECIP   = (1 << tspd_pkg::PAL_RECIP_SHIFT) / PaletteRomBytes + 1;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = tspd_pkg::PATTERN_AW + RECIP_W;

    logic [7:0] r_tile_mem   [tspd_pkg::TILE_ROM_BYTES];
    logic [7:0] r_sprite_mem [tspd_pkg::SPRITE_ROM_BYTES];
    logic [7:0] r_tile_byte;
    logic [7:0] r_sprite_byte;
    logic       r_valid;
    tspd_pkg::t_pat_ctl r_ctl;

    logic                           w_en;
    logic [3:0]                     w_sx;
    logic [3:0]                     w_sy;
    logic [1:0]                     w_row;
    logic [tspd_pkg::PATTERN_AW-1:0] w_tile_addr;
    logic [tspd_pkg::PATTERN_AW-1:0] w_sprite_addr;
    logic [PROD_W-1:0]              w_prod;
    tspd_pkg::t_pat_ctl             n_ctl;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Sprite flips, then the sprite layout: right half first, rows rotated.
    assign w_sx  = i_req.mirror_x ? ~i_req.pixel_x : i_req.pixel_x;
    assign w_sy  = i_req.mirror_y ? ~i_req.pixel_y : i_req.pixel_y;
    assign w_row = w_sy[3:2] + 2'd1;

    assign w_tile_addr   = {i_req.pattern_index, ~i_req.pixel_y[2], ~i_req.pixel_x[2:0]};
    assign w_sprite_addr = {i_req.pattern_index[5:0], ~w_sx[3], w_row, ~w_sx[2:0]};

    // Palette load address divided by the palette size through a reciprocal.
    assign w_prod = PROD_W'(i_req.load_address) * PROD_W'(RECIP);

    always_comb begin
        n_ctl.kind         = i_req.kind;
        n_ctl.pal          = i_req.palette_index[4:0];
        n_ctl.bit_sel      = (i_req.kind == tspd_pkg::KIND_SPRITE_PIXEL) ?
                             ~w_sy[1:0] : ~i_req.pixel_y[1:0];
        n_ctl.load_address = i_req.load_address;
        n_ctl.load_data    = i_req.load_data;
        n_ctl.pal_quot     = w_prod[tspd_pkg::PAL_RECIP_SHIFT +: tspd_pkg::PAL_Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl         <= n_ctl;
            r_tile_byte   <= r_tile_mem[w_tile_addr];
            r_sprite_byte <= r_sprite_mem[w_sprite_addr];
            if (i_valid && i_req.kind == tspd_pkg::KIND_LOAD_TILE) begin
                r_tile_mem[i_req.load_address] <= i_req.load_data;
            end
            if (i_valid && i_req.kind == tspd_pkg::KIND_LOAD_SPRITE) begin
                r_sprite_mem[i_req.load_address] <= i_req.load_data;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_ctl          = r_ctl;
    assign o_pattern_byte = (r_ctl.kind == tspd_pkg::KIND_SPRITE_PIXEL) ?
                            r_sprite_byte : r_tile_byte;

endmodule

`default_nettype wire

>>> design/tspd_palette_stage.sv
// ============================================================================
// tspd_palette_stage - two-bit code extraction and palette store access
// Picks the pixel's two plane bits, reads the palette entry for the code
// and for entry zero, and takes palette loads.
// ============================================================================
`default_nettype none

module tspd_palette_stage #(
    parameter int PaletteRomBytes = tspd_pkg::PALETTE_ROM_BYTES
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  tspd_pkg::t_pat_ctl  i_ctl,
    input  wire  [7:0]          i_pattern_byte,
    output logic                o_ready,
    input  wire                 i_ready,
    output logic                o_valid,
    output tspd_pkg::t_pal_ctl  o_ctl,
    output logic [7:0]          o_entry,
    output logic [7:0]          o_entry0
);

    localparam int PAL_AW = $clog2(PaletteRomBytes);
    localparam int SUB_W  = tspd_pkg::PATTERN_AW + 1;

    logic [7:0] r_mem [PaletteRomBytes];
    logic [7:0] r_entry;
    logic [7:0] r_entry0;
    logic       r_valid;
    tspd_pkg::t_pal_ctl r_ctl;

    logic              w_en;
    logic [1:0]        w_code;
    logic [PAL_AW-1:0] w_rd_addr;
    logic [PAL_AW-1:0] w_rd_addr0;
    logic [SUB_W-1:0]  w_qn;
    logic [SUB_W-1:0]  w_rem;
    tspd_pkg::t_pal_ctl n_ctl;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // Low plane in the low nibble, high plane four bits above it.
    assign w_code = {i_pattern_byte[{1'b1, i_ctl.bit_sel}],
                     i_pattern_byte[{1'b0, i_ctl.bit_sel}]};

    assign w_rd_addr  = PAL_AW'({i_ctl.pal, w_code});
    assign w_rd_addr0 = PAL_AW'({i_ctl.pal, 2'b00});

    // Remainder of the load address, from the quotient found upstream.
    assign w_qn  = SUB_W'(i_ctl.pal_quot) * SUB_W'(PaletteRomBytes);
    assign w_rem = SUB_W'(i_ctl.load_address) - w_qn;

    always_comb begin
        n_ctl.kind        = i_ctl.kind;
        n_ctl.code        = w_code;
        n_ctl.colour_addr = i_ctl.load_address[tspd_pkg::COLOUR_AW-1:0];
        n_ctl.load_data   = i_ctl.load_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl    <= n_ctl;
            r_entry  <= r_mem[w_rd_addr];
            r_entry0 <= r_mem[w_rd_addr0];
            if (i_valid && i_ctl.kind == tspd_pkg::KIND_LOAD_PALETTE) begin
                r_mem[w_rem[PAL_AW-1:0]] <= i_ctl.load_data;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_entry  = r_entry;
    assign o_entry0 = r_entry0;

endmodule

`default_nettype wire

>>> design/tspd_colour_stage.sv
// ============================================================================
// tspd_colour_stage - colour store access
// Reads the colour bytes of the pixel's palette entry and of entry zero,
// and takes colour loads.
// ============================================================================
`default_nettype none

module tspd_colour_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  tspd_pkg::t_pal_ctl  i_ctl,
    input  wire  [7:0]          i_entry,
    input  wire  [7:0]          i_entry0,
    output logic                o_ready,
    input  wire                 i_ready,
    output logic                o_valid,
    output tspd_pkg::t_col_ctl  o_ctl,
    output logic [7:0]          o_colour,
    output logic [7:0]          o_colour0
);

    logic [7:0] r_mem [tspd_pkg::COLOUR_ROM_BYTES];
    logic [7:0] r_colour;
    logic [7:0] r_colour0;
    logic       r_valid;
    tspd_pkg::t_col_ctl r_ctl;

    logic w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    // Palette entries are masked to five bits before indexing colours.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ctl.kind <= i_ctl.kind;
            r_ctl.code <= i_ctl.code;
            r_colour   <= r_mem[i_entry[tspd_pkg::COLOUR_AW-1:0]];
            r_colour0  <= r_mem[i_entry0[tspd_pkg::COLOUR_AW-1:0]];
            if (i_valid && i_ctl.kind == tspd_pkg::KIND_LOAD_COLOUR) begin
                r_mem[i_ctl.colour_addr] <= i_ctl.load_data;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_ctl     = r_ctl;
    assign o_colour  = r_colour;
    assign o_colour0 = r_colour0;

endmodule

`default_nettype wire
